### hw/rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the longest-prefix route lookup block.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Table geometry
  localparam int TableDepth = 128;
  localparam int IdxW       = 7;   // slot index width, fixed by the item field
  localparam int CntW       = 8;   // entry count register width
  localparam int NumPorts   = 4;
  localparam int PortW      = 2;
  localparam int AddrW      = 32;
  localparam int MetricW    = 16;

  // Item kinds
  typedef enum logic {
    KindWrite  = 1'b0,
    KindLookup = 1'b1
  } lpr_kind_e;

  // Input transaction
  typedef struct packed {
    lpr_kind_e            kind;
    logic [IdxW-1:0]      entry_index;
    logic [AddrW-1:0]     entry_network;
    logic [AddrW-1:0]     entry_mask;
    logic [MetricW-1:0]   entry_metric;
    logic [PortW-1:0]     entry_port;
    logic                 entry_is_ipv4;
    logic [AddrW-1:0]     dest_addr;
  } lpr_in_t;

  // Result transaction
  typedef struct packed {
    logic                 found;
    logic [PortW-1:0]     out_port;
    logic [IdxW-1:0]      route_index;
    logic [AddrW-1:0]     route_mask;
  } lpr_out_t;

  // One stored route, one memory word
  typedef struct packed {
    logic                 ipv4;
    logic [PortW-1:0]     port;
    logic [MetricW-1:0]   metric;
    logic [AddrW-1:0]     mask;
    logic [AddrW-1:0]     net;
  } lpr_route_t;

  localparam int RouteW = $bits(lpr_route_t);

  // Control from the sequencer to the best-route tracker
  typedef struct packed {
    logic                 clear;     // start of a new transaction
    logic                 rd_valid;  // memory read data is valid this cycle
    logic [IdxW-1:0]      rd_idx;    // slot of that read data
  } lpr_scan_ctl_t;

  // Current best route
  typedef struct packed {
    logic                 have;
    logic [PortW-1:0]     port;
    logic [IdxW-1:0]      idx;
    logic [AddrW-1:0]     mask;
    logic [MetricW-1:0]   metric;
  } lpr_best_t;

endpackage

### hw/rtl/longest_prefix_route_lookup.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 longest-prefix route table with a linear-scan lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transaction either writes a route into a slot
//                 (kind = write) or looks up dest_addr (kind = lookup).
//   out channel : exactly one result transaction per input transaction;
//                 writes return an all-zero result.
//   cfg channel : entry_count, the number of slots a lookup searches
//                 (saturated to the table depth). Always ready.
// Sequence:
//   A write, or a lookup with N = 0, goes straight to the result state;
//   else a lookup reads one table slot per cycle through the single read
//   port of the route memory over N = min(entry_count, 128) slots, then
//   drains. One transaction is processed at a time; a finished result may
//   still sit in the result register while the next one is accepted.
// Reset:
//   Control state and entry_count clear; the route memory is not cleared
//   and a slot must be written before a lookup reaches it.
// Stalls:
//   The result register holds its transaction while out_ready_i is low; a new
//   input is still accepted, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lpr_pkg::CntW-1:0]  cfg_data_i,
  // input transactions
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lpr_pkg::lpr_in_t          in_data_i,
  // result transactions
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lpr_pkg::lpr_out_t         out_data_o
);
  import lpr_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StDrain  = 4'b0100,
    StResult = 4'b1000
  } lpr_state_e;

  lpr_state_e       state_q, state_d;
  logic [CntW-1:0]  entry_count_q;
  logic [CntW-1:0]  limit_q, limit_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] dest_q, dest_d;
  logic             rd_valid_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             out_valid_q;
  lpr_out_t         out_q;

  logic             in_fire;
  logic             issue;
  logic             last_issue;
  logic             out_load;
  logic [CntW-1:0]  limit_sat;
  lpr_route_t       wr_route;
  lpr_route_t       rd_route;
  lpr_scan_ctl_t    scan_ctl;
  lpr_best_t        best;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  assign limit_sat = (entry_count_q > CntW'(TableDepth)) ? CntW'(TableDepth) : entry_count_q;

  // Handshake and scan control
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (state_q == StScan);
  assign last_issue = issue && ((cnt_q + CntW'(1)) == limit_q);
  assign out_load   = (state_q == StResult) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    limit_d = limit_q;
    dest_d  = dest_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          cnt_d   = '0;
          limit_d = limit_sat;
          dest_d  = in_data_i.dest_addr;
          if (in_data_i.kind == KindLookup && limit_sat != '0) begin
            state_d = StScan;
          end else begin
            state_d = StResult;
          end
        end
      end
      StScan: begin
        cnt_d = cnt_q + CntW'(1);
        if (last_issue) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StResult;
      end
      StResult: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      limit_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      limit_q    <= limit_d;
      rd_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q   <= dest_d;
    rd_idx_q <= cnt_q[IdxW-1:0];
  end

  // Route memory
  assign wr_route.ipv4   = in_data_i.entry_is_ipv4;
  assign wr_route.port   = in_data_i.entry_port;
  assign wr_route.metric = in_data_i.entry_metric;
  assign wr_route.mask   = in_data_i.entry_mask;
  assign wr_route.net    = in_data_i.entry_network;

  lpr_ram #(
    .Width (RouteW),
    .Depth (TableDepth)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_data_i.kind == KindWrite)),
    .waddr_i (in_data_i.entry_index),
    .wdata_i (wr_route),
    .re_i    (issue),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rd_route)
  );

  // Best-route tracker
  assign scan_ctl.clear    = in_fire;
  assign scan_ctl.rd_valid = rd_valid_q;
  assign scan_ctl.rd_idx   = rd_idx_q;

  lpr_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .dest_i (dest_q),
    .route_i(rd_route),
    .best_o (best)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.found       <= best.have;
      out_q.out_port    <= best.have ? best.port : '0;
      out_q.route_index <= best.have ? best.idx  : '0;
      out_q.route_mask  <= best.have ? best.mask : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Read data only follows a scan issue cycle
  a_rd_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q == StScan))
    else $error("read data valid without a scan issue");

  // Scan address stays inside the searched range
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (cnt_q < limit_q))
    else $error("scan address beyond entry count");

  // Drain always consumes the last read of the scan
  a_drain_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> rd_valid_q)
    else $error("drain cycle without pending read data");

  // A result presented on the output was loaded from a result cycle
  a_found_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StResult))
    else $error("result presented outside result state");

endmodule

### hw/rtl/lpr_ram.sv
// ----------------------------------------------------------------------------
// lpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lpr_scan.sv
// ----------------------------------------------------------------------------
// lpr_scan
// Compares each route read from the table against the destination and keeps
// the best match: longest mask, then strictly lower metric, else first found.
// ----------------------------------------------------------------------------
module lpr_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpr_pkg::lpr_scan_ctl_t     ctl_i,
  input  logic [lpr_pkg::AddrW-1:0]  dest_i,
  input  lpr_pkg::lpr_route_t        route_i,
  output lpr_pkg::lpr_best_t         best_o
);
  import lpr_pkg::*;

  lpr_best_t best_q, best_d;
  logic      match;
  logic      better;

  // Route match and preference
  assign match  = route_i.ipv4 && ((dest_i & route_i.mask) == route_i.net);
  assign better = !best_q.have
               || (route_i.mask > best_q.mask)
               || ((route_i.mask == best_q.mask) && (route_i.metric < best_q.metric));

  always_comb begin
    best_d = best_q;
    if (ctl_i.clear) begin
      best_d = '0;
    end else if (ctl_i.rd_valid && match && better) begin
      best_d.have   = 1'b1;
      best_d.port   = route_i.port;
      best_d.idx    = ctl_i.rd_idx;
      best_d.mask   = route_i.mask;
      best_d.metric = route_i.metric;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

  // A fresh transaction starts with no match
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> !best_q.have)
    else $error("best route not cleared at start of transaction");

  // A found match is kept until the next clear
  a_have_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q.have && !ctl_i.clear |=> best_q.have)
    else $error("best route lost during scan");

endmodule

### tb/sv/tb_longest_prefix_route_lookup.sv
// ----------------------------------------------------------------------------
// tb_longest_prefix_route_lookup
// Self-checking testbench for the longest-prefix route lookup block.
// A directed stimulus table covers reset, tie breaking, non-IPv4 and unaligned
// routes, the default route and the field extremes. A random part then fills
// the route table and mixes writes with lookups over several entry counts.
// Every result is checked against a local table model or a typed row result.
// ----------------------------------------------------------------------------
module tb_longest_prefix_route_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  typedef enum logic {RowItem, RowConfig} row_op_e;

  typedef struct {
    row_op_e   op;
    lpr_in_t   item;
    logic [CntW-1:0] count;
    bit        typed;     // result is typed in the row
    lpr_out_t  result;
  } dir_row_t;

  localparam int PhaseItems = 40;
  localparam int NumPhases  = 12;
  localparam int HoldCycles = 300;
  localparam int HoldAtResult = 250;

  // DUT-facing signals, the driven inputs all known from time zero
  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready_o;
  logic [CntW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready_o;
  lpr_in_t         in_data = '0;
  logic            out_valid_o;
  logic            out_ready = 1'b0;
  lpr_out_t        out_data_o;

  // Local copy of the route table and the count register
  lpr_route_t      route_tbl [TableDepth];
  bit              slot_written [TableDepth];
  int unsigned     entry_count = 0;

  lpr_out_t        exp_results [$];
  dir_row_t        dir_rows [$];

  int  err_count = 0;
  int  items_sent = 0;
  int  lookups_sent = 0;
  int  hits_predicted = 0;
  int  results_checked = 0;
  int  cfg_writes = 0;
  bit  src_idles = 1'b1;
  bit  sink_idles = 1'b1;

  longest_prefix_route_lookup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #1_000_000;
    $display("Timeout at %0t", $realtime);
    $display("Test completed with failures");
    $finish;
  end

  // Slots a lookup scans, count saturated to the table depth
  function automatic int unsigned search_limit();
    return (entry_count > TableDepth) ? TableDepth : entry_count;
  endfunction

  // Apply one transaction to the local table and return its result
  function automatic lpr_out_t predict_route(input lpr_in_t it);
    lpr_out_t    res;
    bit          have;
    int unsigned best;
    int unsigned i;
    res  = '0;
    have = 1'b0;
    best = 0;
    if (it.kind == KindWrite) begin
      route_tbl[it.entry_index].net    = it.entry_network;
      route_tbl[it.entry_index].mask   = it.entry_mask;
      route_tbl[it.entry_index].metric = it.entry_metric;
      route_tbl[it.entry_index].port   = it.entry_port;
      route_tbl[it.entry_index].ipv4   = it.entry_is_ipv4;
      slot_written[it.entry_index] = 1'b1;
      return res;
    end
    for (i = 0; i < search_limit(); i++) begin
      if (route_tbl[i].ipv4 != 1'b1) continue;
      if ((it.dest_addr & route_tbl[i].mask) != route_tbl[i].net) continue;
      if (!have) begin
        have = 1'b1;
        best = i;
      end else if (route_tbl[i].mask > route_tbl[best].mask) begin
        best = i;
      end else if (route_tbl[i].mask == route_tbl[best].mask &&
                   route_tbl[i].metric < route_tbl[best].metric) begin
        best = i;
      end
    end
    if (have) begin
      res.found       = 1'b1;
      res.out_port    = route_tbl[best].port;
      res.route_index = best[IdxW-1:0];
      res.route_mask  = route_tbl[best].mask;
      hits_predicted++;
    end
    return res;
  endfunction

  // Directed table rows
  function automatic dir_row_t wr_row(input int idx, input logic [31:0] net,
                                      input logic [31:0] mask, input logic [15:0] metric,
                                      input logic [1:0] port, input logic ipv4);
    dir_row_t r;
    r.op = RowItem;
    r.count = '0;
    r.item = '0;
    r.item.kind = KindWrite;
    r.item.entry_index = idx[IdxW-1:0];
    r.item.entry_network = net;
    r.item.entry_mask = mask;
    r.item.entry_metric = metric;
    r.item.entry_port = port;
    r.item.entry_is_ipv4 = ipv4;
    r.typed = 1'b1;   // a write always returns all zero
    r.result = '0;
    return r;
  endfunction

  function automatic dir_row_t lk_row(input logic [31:0] dest, input bit miss);
    dir_row_t r;
    r.op = RowItem;
    r.count = '0;
    r.item = '0;
    r.item.kind = KindLookup;
    r.item.dest_addr = dest;
    r.typed = miss;
    r.result = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CntW-1:0] v);
    dir_row_t r;
    r.op = RowConfig;
    r.count = v;
    r.item = '0;
    r.typed = 1'b0;
    r.result = '0;
    return r;
  endfunction

  // Random route, nets drawn from a few bases so prefixes overlap
  function automatic lpr_in_t make_route(input int slot);
    lpr_in_t     it;
    int unsigned plen;
    logic [31:0] base;
    it.kind = KindWrite;
    it.entry_index = slot[IdxW-1:0];
    it.dest_addr = $urandom;
    case ($urandom_range(0, 3))
      0: base = 32'h0A00_0000;
      1: base = 32'hC0A8_0000;
      2: base = 32'hAC10_0000;
      default: base = $urandom;
    endcase
    base = base | ($urandom & 32'h0000_FFFF);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 4))
        0: plen = 0;
        1: plen = 8;
        2: plen = 16;
        3: plen = 24;
        default: plen = 32;
      endcase
    end else begin
      plen = $urandom_range(0, 32);
    end
    it.entry_mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
    if ($urandom_range(0, 15) == 0) it.entry_mask = $urandom;
    // mostly aligned networks, some with host bits set
    it.entry_network = ($urandom_range(0, 7) == 0) ? base : (base & it.entry_mask);
    it.entry_metric = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 3));
    it.entry_port = 2'($urandom);
    it.entry_is_ipv4 = ($urandom_range(0, 7) != 0);
    return it;
  endfunction

  // Destination mostly inside a route that the lookup will scan
  function automatic logic [31:0] pick_dest();
    int unsigned s;
    lpr_route_t  r;
    if (search_limit() == 0 || $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: return 32'h0;
        1: return 32'hFFFF_FFFF;
        default: return $urandom;
      endcase
    end
    s = $urandom_range(0, search_limit() - 1);
    r = route_tbl[s];
    return (r.net & r.mask) | ($urandom & ~r.mask);
  endfunction

  // All scanned slots hold a written route
  function automatic bit lookup_is_legal();
    int unsigned i;
    for (i = 0; i < search_limit(); i++)
      if (!slot_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic lpr_in_t random_item();
    lpr_in_t it;
    if ($urandom_range(0, 9) < 3 || !lookup_is_legal()) begin
      it = make_route($urandom_range(0, TableDepth - 1));
    end else begin
      // lookup with junk in the write fields
      it.kind = KindLookup;
      it.entry_index = 7'($urandom);
      it.entry_network = $urandom;
      it.entry_mask = $urandom;
      it.entry_metric = 16'($urandom);
      it.entry_port = 2'($urandom);
      it.entry_is_ipv4 = 1'($urandom);
      it.dest_addr = pick_dest();
    end
    return it;
  endfunction

  // Offer one transaction; returns at the accepting edge with valid still high
  task automatic issue(input lpr_in_t it, input bit typed, input lpr_out_t typed_res);
    lpr_out_t pred;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = predict_route(it);
    exp_results.push_back(typed ? typed_res : pred);
    items_sent++;
    if (it.kind == KindLookup) lookups_sent++;
  endtask

  // Random gap on the input side, when source idling is enabled
  task automatic maybe_gap();
    if (src_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (exp_results.size() != 0) @(posedge clk_i);
  endtask

  // Count register write, only with nothing in flight
  task automatic write_count(input logic [CntW-1:0] v);
    in_valid <= 1'b0;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    entry_count = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checker and output-side idling
  initial begin
    lpr_out_t exp;
    int       stall_left;
    int       hold_left;
    bit       hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $realtime, out_data_o);
          err_count++;
        end else begin
          exp = exp_results.pop_front();
          results_checked++;
          if (out_data_o.found !== exp.found) begin
            $display("%0t: found expected %0h actual %0h",
                     $realtime, exp.found, out_data_o.found);
            err_count++;
          end
          if (out_data_o.out_port !== exp.out_port) begin
            $display("%0t: out_port expected %0h actual %0h",
                     $realtime, exp.out_port, out_data_o.out_port);
            err_count++;
          end
          if (out_data_o.route_index !== exp.route_index) begin
            $display("%0t: route_index expected %0d actual %0d",
                     $realtime, exp.route_index, out_data_o.route_index);
            err_count++;
          end
          if (out_data_o.route_mask !== exp.route_mask) begin
            $display("%0t: route_mask expected %08h actual %08h",
                     $realtime, exp.route_mask, out_data_o.route_mask);
            err_count++;
          end
          // one long hold so the block backs up into its input
          if (!hold_done && results_checked == HoldAtResult) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t        row;
    lpr_in_t         it;
    logic [CntW-1:0] cnt;
    int              phase;
    int              n;
    int              guard;

    // reset, then the directed table: count is 0 right after reset
    dir_rows.push_back(lk_row(32'h0000_0000, 1'b1));
    dir_rows.push_back(lk_row(32'hFFFF_FFFF, 1'b1));
    dir_rows.push_back(wr_row(0, 32'hC0A8_0100, 32'hFFFF_FF00, 16'd10, 2'd1, 1'b1));
    // equal mask, smaller metric takes over
    dir_rows.push_back(wr_row(1, 32'hC0A8_0100, 32'hFFFF_FF00, 16'd5, 2'd2, 1'b1));
    // equal mask and metric, earlier slot stays
    dir_rows.push_back(wr_row(2, 32'hC0A8_0100, 32'hFFFF_FF00, 16'd5, 2'd0, 1'b1));
    // longer prefix but not IPv4, never chosen
    dir_rows.push_back(wr_row(3, 32'hC0A8_0101, 32'hFFFF_FFFF, 16'd0, 2'd3, 1'b0));
    dir_rows.push_back(wr_row(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd2, 1'b1));
    dir_rows.push_back(wr_row(5, 32'h0A00_0000, 32'hFF00_0000, 16'd0, 2'd1, 1'b1));
    // network with host bits set, never matches
    dir_rows.push_back(wr_row(6, 32'h0A00_0001, 32'hFF00_0000, 16'd0, 2'd3, 1'b1));
    // default route
    dir_rows.push_back(wr_row(7, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 2'd3, 1'b1));
    dir_rows.push_back(wr_row(TableDepth - 1, 32'h0, 32'h8000_0000, 16'h1234, 2'd0, 1'b1));
    dir_rows.push_back(cfg_row(8'd7));
    dir_rows.push_back(lk_row(32'hC0A8_0105, 1'b0));
    dir_rows.push_back(lk_row(32'hC0A8_0101, 1'b0));
    dir_rows.push_back(lk_row(32'hFFFF_FFFF, 1'b0));
    dir_rows.push_back(lk_row(32'h0A12_3456, 1'b0));
    dir_rows.push_back(lk_row(32'h0102_0304, 1'b1));   // default route not scanned
    dir_rows.push_back(lk_row(32'h0000_0000, 1'b1));
    dir_rows.push_back(cfg_row(8'd8));
    dir_rows.push_back(lk_row(32'h0102_0304, 1'b0));
    dir_rows.push_back(lk_row(32'h0000_0000, 1'b0));
    dir_rows.push_back(lk_row(32'hC0A8_01FF, 1'b0));
    dir_rows.push_back(cfg_row(8'd1));
    dir_rows.push_back(lk_row(32'hC0A8_0105, 1'b0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.op == RowConfig) begin
        write_count(row.count);
      end else begin
        maybe_gap();
        issue(row.item, row.typed, row.result);
      end
    end

    // fill every slot so any count is legal
    for (n = 0; n < TableDepth; n++) begin
      maybe_gap();
      issue(make_route(n), 1'b0, '0);
    end

    // mixed phases over several counts, extremes first
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: cnt = 8'hFF;
        1: cnt = 8'(TableDepth);
        2: cnt = 8'h00;
        3: cnt = 8'h01;
        default: cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                       8'($urandom_range(1, 16));
      endcase
      if (phase == NumPhases - 1) begin
        src_idles  = 1'b0;
        sink_idles = 1'b0;
      end else begin
        src_idles  = ($urandom_range(0, 3) != 0);
        sink_idles = ($urandom_range(0, 3) != 0);
      end
      write_count(cnt);
      for (n = 0; n < PhaseItems; n++) begin
        maybe_gap();
        it = random_item();
        issue(it, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain and let any stray result show up
    guard = 0;
    while (exp_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (exp_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, exp_results.size());
      err_count++;
    end

    $display("Sent %0d transactions (%0d lookups, %0d predicted hits) over %0d count settings.",
             items_sent, lookups_sent, hits_predicted, cfg_writes);
    $display("Checked %0d results, %0d mismatches.", results_checked, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_ram.sv
hw/rtl/lpr_scan.sv
hw/rtl/longest_prefix_route_lookup.sv
tb/sv/tb_longest_prefix_route_lookup.sv
